FILE: hw/rtl/edf_pkg.sv
// Shared types and event codes for the EDF periodic task scheduler.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package edf_pkg;

	// Event codes carried in event_res
	localparam logic [2:0] EV_START   = 3'd0;
	localparam logic [2:0] EV_RESUME  = 3'd1;
	localparam logic [2:0] EV_FINISH  = 3'd2;
	localparam logic [2:0] EV_MISSED  = 3'd3;
	localparam logic [2:0] EV_PREEMPT = 3'd4;
	localparam logic [2:0] EV_IDLE    = 3'd5;
	localparam logic [2:0] EV_DONE    = 3'd6;

	// Command codes carried in func
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        func;
		logic [2:0]  slot;
		logic [7:0]  task_id;
		logic [15:0] exec_time;
		logic [15:0] period;
		logic [15:0] job_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  event_task;
		logic [7:0]  preemptor_task;
		logic [31:0] event_time;
		logic [31:0] completed_total;
		logic [31:0] missed_total;
		logic        last;
	} res_t;

	// Control from the sequencer to the event output stage
	typedef struct packed {
		logic push;
		logic flush;
	} evt_ctl_t;

	// Result of the shared deadline compare unit
	typedef struct packed {
		logic [31:0] gap;
		logic        take;
		logic        at_now;
	} cmp_res_t;

endpackage

FILE: hw/rtl/edf_cmp_unit.sv
// Shared deadline compare unit: distance from now, earliest test, due test.
// Depends on edf_pkg.
`timescale 1ns / 1ps

module edf_cmp_unit (
	input  logic              cand,
	input  logic              best_found,
	input  logic [31:0]       deadline,
	input  logic [31:0]       now_time,
	input  logic [31:0]       best_dist,
	output edf_pkg::cmp_res_t res
);
	import edf_pkg::*;

	logic [31:0] gap;

	// Measure the deadline as a distance from now so wrap compares right
	assign gap        = deadline - now_time;
	assign res.gap    = gap;
	assign res.take   = cand && (!best_found || (gap < best_dist));
	assign res.at_now = (gap == 32'd0);

endmodule

FILE: hw/rtl/edf_evt_out.sv
// Event output stage: holds one pending beat so the final beat of a tick
// can be marked last. Depends on edf_pkg.
`timescale 1ns / 1ps

module edf_evt_out (
	input  logic              clk,
	input  logic              arst_n,
	input  edf_pkg::evt_ctl_t ctl,
	input  edf_pkg::res_t     evt,
	output edf_pkg::res_t     result,
	output logic              result_valid
);
	import edf_pkg::*;

	res_t pend_q;
	logic pend_v_q;
	res_t out_q;
	logic out_v_q;
	res_t mid_beat;
	res_t fin_beat;

	// Control: pending flag and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else if (ctl.push) begin
			out_v_q  <= pend_v_q;
			pend_v_q <= 1'b1;
		end else if (ctl.flush) begin
			out_v_q  <= pend_v_q;
			pend_v_q <= 1'b0;
		end else begin
			out_v_q  <= 1'b0;
		end
	end

	// Mark the pending beat as inner or final
	always_comb begin
		mid_beat      = pend_q;
		mid_beat.last = 1'b0;
		fin_beat      = pend_q;
		fin_beat.last = 1'b1;
	end

	// Payload: shift pending beat out, mark last on flush
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			out_q  <= mid_beat;
			pend_q <= evt;
		end else if (ctl.flush) begin
			out_q  <= fin_beat;
		end
	end

	assign result       = out_q;
	assign result_valid = out_v_q;

endmodule

FILE: hw/rtl/edf_periodic_task_scheduler_core.sv
// EDF periodic task scheduler core: slot registers, sequencer, compare unit.
// Depends on edf_pkg, edf_cmp_unit and edf_evt_out. A tick holds busy through scan,
// decide, run, release pass, rescan, preempt check and wrap-up through one compare unit;
// on idle the run step is skipped, and if none are live decide goes straight to wrap-up.
// Beats leave at most one per cycle; the last sits on the ports the first cycle busy is low.
// The receiver cannot stall. Reset empties all slots and clears time and totals.
`timescale 1ns / 1ps

module edf_periodic_task_scheduler_core #(
	parameter int NUM_TASKS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  edf_pkg::in_item_t item,
	output edf_pkg::res_t     result,
	output logic              result_valid
);
	import edf_pkg::*;

	localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TASKS - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN1  = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_RUN    = 3'd3;
	localparam logic [2:0] ST_REL    = 3'd4;
	localparam logic [2:0] ST_SCAN2  = 3'd5;
	localparam logic [2:0] ST_PRE    = 3'd6;
	localparam logic [2:0] ST_FIN    = 3'd7;

	logic [2:0]    state_q;
	logic          valid_q  [NUM_TASKS];
	logic          ready_q  [NUM_TASKS];
	logic [7:0]    id_q     [NUM_TASKS];
	logic [15:0]   exec_q   [NUM_TASKS];
	logic [15:0]   period_q [NUM_TASKS];
	logic [15:0]   jobs_q   [NUM_TASKS];
	logic [15:0]   rem_q    [NUM_TASKS];
	logic [31:0]   dl_q     [NUM_TASKS];
	logic [31:0]   now_q, done_q, miss_q;
	logic [IW-1:0] run_slot_q, idx_q, best_q;
	logic          run_v_q, found_q, live_q;
	logic [31:0]   best_dist_q;
	logic [7:0]    best_id_q;

	logic          accept, do_load;
	logic [IW-1:0] ld_idx, rd_idx;
	logic          r_valid, r_ready;
	logic [7:0]    r_id;
	logic [15:0]   r_exec, r_period, r_jobs, r_rem, rem_new, jobs_rel;
	logic [31:0]   r_dl, done_inc, miss_inc, now_inc;
	logic          fin_hit, rel_hit, rel_miss, same_run;
	cmp_res_t      cmp;
	evt_ctl_t      ctl;
	res_t          evt;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign do_load = accept && (item.func == FUNC_LOAD) && (32'(item.slot) < NUM_TASKS);
	assign ld_idx  = IW'(item.slot);

	// Select the single slot read address for this step
	always_comb begin
		if (state_q inside {ST_SCAN1, ST_SCAN2, ST_REL}) begin
			rd_idx = idx_q;
		end else if (state_q == ST_PRE) begin
			rd_idx = run_slot_q;
		end else begin
			rd_idx = best_q;
		end
	end

	assign r_valid  = valid_q[rd_idx];
	assign r_ready  = ready_q[rd_idx];
	assign r_id     = id_q[rd_idx];
	assign r_exec   = exec_q[rd_idx];
	assign r_period = period_q[rd_idx];
	assign r_jobs   = jobs_q[rd_idx];
	assign r_rem    = rem_q[rd_idx];
	assign r_dl     = dl_q[rd_idx];

	edf_cmp_unit u_cmp (
		.cand      (r_valid && r_ready),
		.best_found(found_q),
		.deadline  (r_dl),
		.now_time  (now_q),
		.best_dist (best_dist_q),
		.res       (cmp)
	);

	assign done_inc = (done_q == CNT_MAX) ? done_q : done_q + 32'd1;
	assign miss_inc = (miss_q == CNT_MAX) ? miss_q : miss_q + 32'd1;
	assign now_inc  = now_q + 32'd1;
	assign rem_new  = (r_rem != 16'd0) ? r_rem - 16'd1 : r_rem;
	assign fin_hit  = (rem_new == 16'd0);
	assign rel_hit  = r_valid && cmp.at_now;
	assign rel_miss = rel_hit && r_ready;
	assign jobs_rel = (rel_miss && r_jobs != 16'd0) ? r_jobs - 16'd1 : r_jobs;
	assign same_run = run_v_q && (run_slot_q == best_q);

	// Build the event beat for the current step
	always_comb begin
		ctl                 = '0;
		evt                 = '0;
		evt.completed_total = done_q;
		evt.missed_total    = miss_q;
		evt.event_time      = now_q;
		case (state_q)
			ST_DECIDE: begin
				if (!live_q) begin
					ctl.push      = 1'b1;
					evt.event_res = EV_DONE;
				end else if (!found_q) begin
					ctl.push      = 1'b1;
					evt.event_res = EV_IDLE;
				end else if (!same_run) begin
					ctl.push       = 1'b1;
					evt.event_res  = (r_rem == r_exec) ? EV_START : EV_RESUME;
					evt.event_task = r_id;
				end
			end
			ST_RUN: begin
				if (fin_hit) begin
					ctl.push            = 1'b1;
					evt.event_res       = EV_FINISH;
					evt.event_task      = r_id;
					evt.event_time      = now_inc;
					evt.completed_total = done_inc;
				end
			end
			ST_REL: begin
				if (rel_miss) begin
					ctl.push       = 1'b1;
					evt.event_res  = EV_MISSED;
					evt.event_task = r_id;
				end
			end
			ST_PRE: begin
				if (run_v_q && found_q && (best_q != run_slot_q)) begin
					ctl.push           = 1'b1;
					evt.event_res      = EV_PREEMPT;
					evt.event_task     = r_id;
					evt.preemptor_task = best_id_q;
				end
			end
			ST_FIN: begin
				ctl.flush = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			now_q      <= '0;
			done_q     <= '0;
			miss_q     <= '0;
			run_slot_q <= '0;
			run_v_q    <= 1'b0;
			idx_q      <= '0;
			best_q     <= '0;
			found_q    <= 1'b0;
			live_q     <= 1'b0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				valid_q[i] <= 1'b0;
				ready_q[i] <= 1'b0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (do_load) begin
						valid_q[ld_idx] <= (item.job_count != 16'd0);
						ready_q[ld_idx] <= (item.job_count != 16'd0);
						if (run_v_q && run_slot_q == ld_idx) begin
							run_v_q <= 1'b0;
						end
					end
					if (accept && item.func == FUNC_TICK) begin
						state_q <= ST_SCAN1;
						idx_q   <= '0;
						found_q <= 1'b0;
						live_q  <= 1'b0;
					end
				end
				ST_SCAN1, ST_SCAN2: begin
					live_q <= live_q | r_valid;
					if (cmp.take) begin
						found_q <= 1'b1;
						best_q  <= idx_q;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= (state_q == ST_SCAN1) ? ST_DECIDE : ST_PRE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					if (!live_q) begin
						run_v_q <= 1'b0;
						state_q <= ST_FIN;
					end else if (!found_q) begin
						run_v_q <= 1'b0;
						now_q   <= now_inc;
						idx_q   <= '0;
						state_q <= ST_REL;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					now_q <= now_inc;
					if (fin_hit) begin
						done_q          <= done_inc;
						ready_q[best_q] <= 1'b0;
						if (r_jobs <= 16'd1) begin
							valid_q[best_q] <= 1'b0;
						end
						run_v_q <= 1'b0;
					end else begin
						run_v_q    <= 1'b1;
						run_slot_q <= best_q;
					end
					idx_q   <= '0;
					state_q <= ST_REL;
				end
				ST_REL: begin
					if (rel_hit) begin
						if (rel_miss) begin
							miss_q <= miss_inc;
							if (run_v_q && run_slot_q == idx_q) begin
								run_v_q <= 1'b0;
							end
						end
						if (jobs_rel == 16'd0) begin
							valid_q[idx_q] <= 1'b0;
							ready_q[idx_q] <= 1'b0;
						end else begin
							ready_q[idx_q] <= 1'b1;
						end
					end
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						live_q  <= 1'b0;
						state_q <= ST_SCAN2;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_PRE: begin
					if (run_v_q && found_q && (best_q != run_slot_q)) begin
						run_v_q <= 1'b0;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Slot payload and scan payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && do_load) begin
			id_q[ld_idx]     <= item.task_id;
			exec_q[ld_idx]   <= (item.exec_time == 16'd0) ? 16'd1 : item.exec_time;
			period_q[ld_idx] <= (item.period == 16'd0) ? 16'd1 : item.period;
			jobs_q[ld_idx]   <= item.job_count;
			rem_q[ld_idx]    <= (item.exec_time == 16'd0) ? 16'd1 : item.exec_time;
			dl_q[ld_idx]     <= now_q + ((item.period == 16'd0) ? 32'd1 : 32'(item.period));
		end
		if ((state_q == ST_SCAN1 || state_q == ST_SCAN2) && cmp.take) begin
			best_dist_q <= cmp.gap;
			best_id_q   <= r_id;
		end
		if (state_q == ST_RUN) begin
			rem_q[best_q] <= rem_new;
			if (fin_hit && r_jobs != 16'd0) begin
				jobs_q[best_q] <= r_jobs - 16'd1;
			end
		end
		if (state_q == ST_REL && rel_hit) begin
			jobs_q[idx_q] <= jobs_rel;
			if (jobs_rel != 16'd0) begin
				dl_q[idx_q]  <= r_dl + 32'(r_period);
				rem_q[idx_q] <= r_exec;
			end
		end
	end

	edf_evt_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.evt         (evt),
		.result      (result),
		.result_valid(result_valid)
	);

	// Check: beats only leave while a tick is in flight or just ended
	a_beat_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result beat outside a tick");

	// Check: the final beat of a tick is never followed at once by another
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |=> !result_valid)
		else $error("beat right after last beat");

	// Check: the wrap-up step always returns to idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle");

endmodule
